// File: src/resp_reply_byte_parser_macros.svh
// Assertion macros for the reply byte parser.
`ifndef RESP_REPLY_BYTE_PARSER_MACROS_SVH
`define RESP_REPLY_BYTE_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define RRBP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define RRBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define RRBP_ASSERT_IMPLY(label, ante, cons)
`define RRBP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/rrbp_pkg.sv
// Shared types and constants for the reply byte parser.
package rrbp_pkg;

    // Register and parameter defaults
    localparam int MAX_LEN_BITS = 30;
    localparam int LENGTH_BITS_DEF = 30;
    localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 30'd536870912;

    // Parser phases
    localparam logic [3:0] PH_WAIT       = 4'd0;
    localparam logic [3:0] PH_LINE       = 4'd1;
    localparam logic [3:0] PH_LINE_LF    = 4'd2;
    localparam logic [3:0] PH_LEN_SIGN   = 4'd3;
    localparam logic [3:0] PH_LEN_DIGITS = 4'd4;
    localparam logic [3:0] PH_LEN_SKIP   = 4'd5;
    localparam logic [3:0] PH_PAYLOAD    = 4'd6;
    localparam logic [3:0] PH_TRAIL1     = 4'd7;
    localparam logic [3:0] PH_TRAIL2     = 4'd8;

    // Error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_TYPE  = 3'd1;
    localparam logic [2:0] ERR_DIGIT = 3'd2;
    localparam logic [2:0] ERR_NOLF  = 3'd3;
    localparam logic [2:0] ERR_MULTI = 3'd4;
    localparam logic [2:0] ERR_LONG  = 3'd5;

    // Reply kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ERROR  = 2'd1;
    localparam logic [1:0] KIND_INT    = 2'd2;
    localparam logic [1:0] KIND_BULK   = 2'd3;

    // Protocol characters
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // One result item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic [1:0] reply_kind;
        logic       reply_end;
        logic       is_null;
        logic [2:0] error_code;
    } result_t;

endpackage

// File: src/rrbp_parse_core.sv
// Parser state and per-byte decode logic.
module rrbp_parse_core #(
    parameter int LENGTH_BITS = rrbp_pkg::LENGTH_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic [7:0]                          in_byte,
    input  logic [rrbp_pkg::MAX_LEN_BITS-1:0]   max_len,
    output logic                                res_valid,
    output rrbp_pkg::result_t                   res
);

    localparam int PW = LENGTH_BITS + 4;
    localparam int CW = (LENGTH_BITS > rrbp_pkg::MAX_LEN_BITS) ?
                        LENGTH_BITS : rrbp_pkg::MAX_LEN_BITS;

    logic [3:0]             phase_reg, phase_next;
    logic [1:0]             kind_reg, kind_next;
    logic                   neg_reg, neg_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [PW-1:0]          prod;
    logic                   ovf;
    logic                   too_big;
    logic [LENGTH_BITS-1:0] rem_dec;

    // Next length value: acc * 10 + digit, with headroom to see overflow
    assign is_digit = (in_byte >= rrbp_pkg::CH_ZERO) && (in_byte <= rrbp_pkg::CH_NINE);
    assign digit    = in_byte[3:0];
    assign prod     = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + PW'(digit);
    assign ovf      = |prod[PW-1:LENGTH_BITS];
    assign too_big  = CW'(prod[LENGTH_BITS-1:0]) > CW'(max_len);
    assign rem_dec  = rem_reg - LENGTH_BITS'(1);

    // Decode one byte against the current phase
    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.reply_kind = kind_reg;

        unique case (phase_reg) inside
            rrbp_pkg::PH_LINE:
            begin
                if (in_byte == rrbp_pkg::CH_CR)
                begin
                    phase_next = rrbp_pkg::PH_LINE_LF;
                end
                else
                begin
                    res_valid      = 1'b1;
                    res.data_byte  = in_byte;
                    res.data_valid = 1'b1;
                end
            end

            rrbp_pkg::PH_LINE_LF:
            begin
                phase_next = rrbp_pkg::PH_WAIT;
                res_valid  = 1'b1;
                if (in_byte != rrbp_pkg::CH_LF)
                begin
                    res.error_code = rrbp_pkg::ERR_NOLF;
                end
                else
                begin
                    res.reply_end = 1'b1;
                end
            end

            rrbp_pkg::PH_LEN_SIGN, rrbp_pkg::PH_LEN_DIGITS:
            begin
                if ((phase_reg == rrbp_pkg::PH_LEN_SIGN) &&
                    ((in_byte == rrbp_pkg::CH_MINUS) || (in_byte == rrbp_pkg::CH_PLUS)))
                begin
                    neg_next   = (in_byte == rrbp_pkg::CH_MINUS);
                    phase_next = rrbp_pkg::PH_LEN_DIGITS;
                end
                else if (in_byte == rrbp_pkg::CH_CR)
                begin
                    phase_next = rrbp_pkg::PH_LEN_SKIP;
                end
                else if (!is_digit)
                begin
                    phase_next     = rrbp_pkg::PH_WAIT;
                    res_valid      = 1'b1;
                    res.error_code = rrbp_pkg::ERR_DIGIT;
                end
                else
                begin
                    phase_next = rrbp_pkg::PH_LEN_DIGITS;
                    if (ovf)
                    begin
                        // Saturate a negative length, reject a positive one
                        acc_next = '1;
                        if (!neg_reg)
                        begin
                            phase_next     = rrbp_pkg::PH_WAIT;
                            res_valid      = 1'b1;
                            res.error_code = rrbp_pkg::ERR_LONG;
                        end
                    end
                    else
                    begin
                        acc_next = prod[LENGTH_BITS-1:0];
                        if (!neg_reg && too_big)
                        begin
                            phase_next     = rrbp_pkg::PH_WAIT;
                            res_valid      = 1'b1;
                            res.error_code = rrbp_pkg::ERR_LONG;
                        end
                    end
                end
            end

            rrbp_pkg::PH_LEN_SKIP:
            begin
                if (neg_reg && (acc_reg != '0))
                begin
                    phase_next     = rrbp_pkg::PH_WAIT;
                    res_valid      = 1'b1;
                    res.reply_kind = rrbp_pkg::KIND_BULK;
                    res.reply_end  = 1'b1;
                    res.is_null    = 1'b1;
                end
                else
                begin
                    rem_next   = acc_reg;
                    phase_next = (acc_reg == '0) ? rrbp_pkg::PH_TRAIL1 : rrbp_pkg::PH_PAYLOAD;
                end
            end

            rrbp_pkg::PH_PAYLOAD:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = rrbp_pkg::PH_TRAIL1;
                end
                res_valid      = 1'b1;
                res.data_byte  = in_byte;
                res.data_valid = 1'b1;
                res.reply_kind = rrbp_pkg::KIND_BULK;
            end

            rrbp_pkg::PH_TRAIL1:
            begin
                phase_next = rrbp_pkg::PH_TRAIL2;
            end

            rrbp_pkg::PH_TRAIL2:
            begin
                phase_next     = rrbp_pkg::PH_WAIT;
                res_valid      = 1'b1;
                res.reply_kind = rrbp_pkg::KIND_BULK;
                res.reply_end  = 1'b1;
            end

            default:
            begin
                // Wait for a type byte; clear length state
                neg_next = 1'b0;
                acc_next = '0;
                rem_next = '0;
                if (in_byte == rrbp_pkg::CH_PLUS)
                begin
                    kind_next  = rrbp_pkg::KIND_STATUS;
                    phase_next = rrbp_pkg::PH_LINE;
                end
                else if (in_byte == rrbp_pkg::CH_MINUS)
                begin
                    kind_next  = rrbp_pkg::KIND_ERROR;
                    phase_next = rrbp_pkg::PH_LINE;
                end
                else if (in_byte == rrbp_pkg::CH_COLON)
                begin
                    kind_next  = rrbp_pkg::KIND_INT;
                    phase_next = rrbp_pkg::PH_LINE;
                end
                else if (in_byte == rrbp_pkg::CH_DOLLAR)
                begin
                    kind_next  = rrbp_pkg::KIND_BULK;
                    phase_next = rrbp_pkg::PH_LEN_SIGN;
                end
                else
                begin
                    kind_next      = rrbp_pkg::KIND_STATUS;
                    phase_next     = rrbp_pkg::PH_WAIT;
                    res_valid      = 1'b1;
                    res.reply_kind = rrbp_pkg::KIND_STATUS;
                    res.error_code = (in_byte == rrbp_pkg::CH_STAR) ?
                                     rrbp_pkg::ERR_MULTI : rrbp_pkg::ERR_TYPE;
                end
            end
        endcase
    end

    // Advance parser state on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rrbp_pkg::PH_WAIT;
            kind_reg  <= rrbp_pkg::KIND_STATUS;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// File: src/rrbp_out_stage.sv
// Output register holding one result item until it is taken.
module rrbp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  rrbp_pkg::result_t res,
    input  logic              out_stall,
    output logic              out_valid,
    output logic              out_free,
    output rrbp_pkg::result_t out_res
);

    logic              valid_reg;
    rrbp_pkg::result_t res_reg;

    // Free when empty or when the held item leaves this cycle
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // Track occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// File: src/resp_reply_byte_parser.sv
// Top level of the reply byte parser: input register, parser core, output register.
//
//  Channel   Signals                                         Direction
//  -------   ----------------------------------------------  ---------
//  in        in_valid, in_stall, in_byte                     byte in
//  out       out_valid, out_stall, data_byte, data_valid,    item out
//            reply_kind, reply_end, is_null, error_code
//  cfg       cfg_we, cfg_wdata (max_bulk_length)             write only
//
// One byte is taken per cycle while in_stall is low; a result passes through the
// input register and then the output register around the decode.
// Reset clears the parser to waiting for a type byte and max_bulk_length to 2^29.
// A stall on the output holds the result and, once the input register is also
// full, raises in_stall; no cycle is lost once out_stall drops.
`include "resp_reply_byte_parser_macros.svh"

module resp_reply_byte_parser #(
    parameter int LENGTH_BITS = rrbp_pkg::LENGTH_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_byte,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        data_byte,
    output logic                              data_valid,
    output logic [1:0]                        reply_kind,
    output logic                              reply_end,
    output logic                              is_null,
    output logic [2:0]                        error_code,
    input  logic                              cfg_we,
    input  logic [rrbp_pkg::MAX_LEN_BITS-1:0] cfg_wdata
);

    logic                              in_valid_reg;
    logic [7:0]                        in_byte_reg;
    logic [rrbp_pkg::MAX_LEN_BITS-1:0] max_len_reg;
    logic                              out_free;
    logic                              fire;
    logic                              in_take;
    logic                              res_valid;
    rrbp_pkg::result_t                 res;
    rrbp_pkg::result_t                 out_res;
    logic                              out_error;
    logic                              out_bare;
    logic                              out_null;
    logic                              bulk_end;

    // Process the held byte when the output register can take its item
    assign fire     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Length limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= rrbp_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    rrbp_parse_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_byte   (in_byte_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    rrbp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_free  (out_free),
        .out_res   (out_res)
    );

    // Drive result fields
    assign data_byte  = out_res.data_byte;
    assign data_valid = out_res.data_valid;
    assign reply_kind = out_res.reply_kind;
    assign reply_end  = out_res.reply_end;
    assign is_null    = out_res.is_null;
    assign error_code = out_res.error_code;

    // Terms for the checks
    assign out_error = out_valid && (error_code != rrbp_pkg::ERR_NONE);
    assign out_bare  = !data_valid && !reply_end && !is_null && (data_byte == 8'd0);
    assign out_null  = out_valid && is_null;
    assign bulk_end  = reply_end && (reply_kind == rrbp_pkg::KIND_BULK);

    // Checks
    `RRBP_ASSERT_IMPLY(a_stall_needs_full, in_stall, in_valid_reg)
    `RRBP_ASSERT_NEXT(a_take_fills_input, in_take, in_valid_reg)
    `RRBP_ASSERT_IMPLY(a_error_is_bare, out_error, out_bare)
    `RRBP_ASSERT_IMPLY(a_null_is_bulk_end, out_null, bulk_end)

endmodule
